FILE: hdl/pcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcps_pkg;

    // image geometry
    localparam int CHANNELS           = 3;
    localparam int PIXELS_PER_CHANNEL = 1024;
    localparam int PIX_SHIFT          = $clog2(PIXELS_PER_CHANNEL);
    localparam int CH_IDX_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // field and statistics widths
    localparam int OP_W      = 2;
    localparam int CH_W      = 2;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 18;
    localparam int SQ_W      = 27;
    localparam int ROOT_W    = 19;
    localparam int OUT_W     = 18;
    localparam int FRAC_BITS = 12;

    // datapath widths
    localparam int PROD_W     = 2 * SUM_W;
    localparam int DIFF_W     = 38;
    localparam int NUM_W      = SUM_W + 1;
    localparam int MAG_W      = SUM_W;
    localparam int DVD_W      = MAG_W + FRAC_BITS;
    localparam int REM_W      = ROOT_W + 4;
    localparam int SATCMP_W   = ROOT_W + OUT_W - FRAC_BITS;
    localparam int SQRT_STEPS = DIFF_W / 2;
    localparam int DIV_STEPS  = OUT_W;
    localparam int STEP_CNT_W = $clog2(SQRT_STEPS + 1);

    // saturation limits of the result
    localparam logic [OUT_W-1:0] OUT_MAX_C = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN_C = {1'b1, {(OUT_W-1){1'b0}}};

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ACCUM = 2'd0,
        OP_NORM  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // command to the shared iteration unit
    typedef struct packed {
        logic start;
        logic div_mode;
    } iter_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/pcps_iter_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module pcps_iter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pcps_pkg::iter_cmd_t                  cmd_i,
    input  logic [pcps_pkg::DIFF_W-1:0]          src_i,
    input  logic [pcps_pkg::REM_W-1:0]           rem_i,
    input  logic [pcps_pkg::ROOT_W-1:0]          divisor_i,
    output logic                                 done_o,
    output logic [pcps_pkg::ROOT_W-1:0]          result_o
);
    import pcps_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic                  mode_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [DIFF_W-1:0]     src_reg, src_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     res_reg, res_next;
    logic [REM_W-1:0]      shifted;
    logic [REM_W-1:0]      trial;
    logic                  ge;

    // one digit step: shared compare and subtract for root and quotient digits
    always_comb begin
        if (mode_reg) begin
            shifted  = {rem_reg[REM_W-2:0], src_reg[DIFF_W-1]};
            trial    = {{(REM_W-ROOT_W){1'b0}}, divisor_i};
            src_next = {src_reg[DIFF_W-2:0], 1'b0};
        end else begin
            shifted  = {rem_reg[REM_W-3:0], src_reg[DIFF_W-1:DIFF_W-2]};
            trial    = {{(REM_W-ROOT_W-2){1'b0}}, res_reg, 2'b01};
            src_next = {src_reg[DIFF_W-3:0], 2'b00};
        end
        ge       = (shifted >= trial);
        rem_next = ge ? (shifted - trial) : shifted;
        res_next = {res_reg[ROOT_W-2:0], ge};
    end

    // step counter and completion flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == STEP_CNT_W'(1));
            if (cmd_i.start) begin
                busy_reg <= 1'b1;
                mode_reg <= cmd_i.div_mode;
                cnt_reg  <= cmd_i.div_mode ? STEP_CNT_W'(DIV_STEPS)
                                           : STEP_CNT_W'(SQRT_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // operand, partial remainder and result registers
    always_ff @(posedge aclk) begin
        if (cmd_i.start) begin
            src_reg <= src_i;
            rem_reg <= rem_i;
            res_reg <= '0;
        end else if (busy_reg) begin
            src_reg <= src_next;
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign done_o   = done_reg;
    assign result_o = res_reg;

endmodule

`default_nettype wire

FILE: hdl/per_channel_pixel_standardizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// accumulate and clear transactions leave the block in idle; the block is ready again next cycle
// normalize with a cached channel root: divide (18 quotient steps), skipped for a zero root or a saturated quotient
// normalize after the channel statistics changed: square, 19 root steps, divide
// both root and quotient digits come from one shared compare/subtract unit, one digit a cycle
// aresetn (synchronous, active low) clears the channel statistics, root valid flags and m_tvalid

module per_channel_pixel_standardizer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic [3:0]  s_tuser,   // [1:0] op, [3:2] channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [17:0] normalized, rest zero
    output logic [0:0]  m_tuser    // [0] zero_spread
);
    import pcps_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_DIFF,
        S_ROOT,
        S_DIVSET,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    // channel statistics
    logic [SUM_W-1:0]  sum_reg  [CHANNELS];
    logic [SQ_W-1:0]   sq_reg   [CHANNELS];
    logic [ROOT_W-1:0] root_reg [CHANNELS];
    logic              root_valid_reg [CHANNELS];

    // per-transaction registers
    logic [CH_IDX_W-1:0] ch_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic                neg_reg;
    logic [OUT_W-1:0]    res_reg;
    logic                zero_reg;
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic                m_tuser_reg;

    // input decode
    logic [OP_W-1:0]     in_op;
    logic [CH_W-1:0]     in_ch;
    logic [CH_IDX_W-1:0] in_idx;
    logic                ch_ok;
    logic                s_fire;
    logic                acc_we;
    logic                clr_we;
    logic                norm_go;
    logic [2*PIX_W-1:0]  pix_sq;

    // datapath
    logic [SUM_W-1:0]    cur_sum;
    logic [SQ_W-1:0]     cur_sq;
    logic [ROOT_W-1:0]   cur_root;
    logic [DIFF_W-1:0]   diff;
    logic                diff_pos;
    logic [NUM_W-1:0]    num;
    logic                num_neg;
    logic [NUM_W-1:0]    num_abs;
    logic [MAG_W-1:0]    mag;
    logic [DVD_W-1:0]    dividend;
    logic                div_sat;
    logic                root_we;
    logic [ROOT_W-1:0]   root_wdata;
    logic [OUT_W-1:0]    quo;
    logic [OUT_W-1:0]    quo_signed;

    // iteration unit interface
    iter_cmd_t           iter_cmd;
    logic [DIFF_W-1:0]   iter_src;
    logic [REM_W-1:0]    iter_rem;
    logic                iter_done;
    logic [ROOT_W-1:0]   iter_res;

    // input transaction decode
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_op    = s_tuser[1:0];
    assign in_ch    = s_tuser[3:2];
    assign in_idx   = in_ch[CH_IDX_W-1:0];
    assign ch_ok    = ({1'b0, in_ch} < (CH_W+1)'(CHANNELS));
    assign acc_we   = s_fire && (in_op == OP_ACCUM) && ch_ok;
    assign clr_we   = s_fire && (in_op == OP_CLEAR);
    assign norm_go  = s_fire && (in_op == OP_NORM) && ch_ok;
    assign pix_sq   = s_tdata * s_tdata;

    // statistics of the channel in work
    assign cur_sum  = sum_reg[ch_reg];
    assign cur_sq   = sq_reg[ch_reg];
    assign cur_root = root_reg[ch_reg];

    // spread term P*sumsq - sum^2
    assign diff = {{(DIFF_W-SQ_W-PIX_SHIFT){1'b0}}, cur_sq, {PIX_SHIFT{1'b0}}}
                - {{(DIFF_W-PROD_W){1'b0}}, prod_reg};
    assign diff_pos = !diff[DIFF_W-1] && (diff != '0);

    // centered numerator P*x - sum and its magnitude
    assign num      = {1'b0, pix_reg, {PIX_SHIFT{1'b0}}} - {1'b0, cur_sum};
    assign num_neg  = num[NUM_W-1];
    assign num_abs  = num_neg ? (~num + NUM_W'(1)) : num;
    assign mag      = num_abs[MAG_W-1:0];
    assign dividend = {mag, {FRAC_BITS{1'b0}}};
    assign div_sat  = ({{(SATCMP_W-MAG_W){1'b0}}, mag}
                       >= {cur_root, {(OUT_W-FRAC_BITS){1'b0}}});

    // root cache write
    assign root_we    = ((state_reg == S_DIFF) && !diff_pos)
                     || ((state_reg == S_ROOT) && iter_done);
    assign root_wdata = (state_reg == S_ROOT) ? iter_res : '0;

    // shared unit commands
    always_comb begin
        iter_cmd.start    = ((state_reg == S_DIFF) && diff_pos)
                         || ((state_reg == S_DIVSET) && (cur_root != '0) && !div_sat);
        iter_cmd.div_mode = (state_reg == S_DIVSET);
        if (state_reg == S_DIVSET) begin
            iter_src = {dividend[OUT_W-1:0], {(DIFF_W-OUT_W){1'b0}}};
            iter_rem = {{(REM_W-(DVD_W-OUT_W)){1'b0}}, dividend[DVD_W-1:OUT_W]};
        end else begin
            iter_src = diff;
            iter_rem = '0;
        end
    end

    // signed, saturated quotient
    assign quo = iter_res[OUT_W-1:0];
    always_comb begin
        if (neg_reg) begin
            quo_signed = (quo > OUT_MIN_C) ? OUT_MIN_C : (~quo + OUT_W'(1));
        end else begin
            quo_signed = (quo > OUT_MAX_C) ? OUT_MAX_C : quo;
        end
    end

    pcps_iter_unit u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (iter_cmd),
        .src_i     (iter_src),
        .rem_i     (iter_rem),
        .divisor_i (cur_root),
        .done_o    (iter_done),
        .result_o  (iter_res)
    );

    // channel statistics and root valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn || clr_we) begin
            for (int i = 0; i < CHANNELS; i++) begin
                sum_reg[i]        <= '0;
                sq_reg[i]         <= '0;
                root_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (acc_we) begin
                sum_reg[in_idx]        <= sum_reg[in_idx] + {{(SUM_W-PIX_W){1'b0}}, s_tdata};
                sq_reg[in_idx]         <= sq_reg[in_idx] + {{(SQ_W-2*PIX_W){1'b0}}, pix_sq};
                root_valid_reg[in_idx] <= 1'b0;
            end
            if (root_we) begin
                root_valid_reg[ch_reg] <= 1'b1;
            end
        end
    end

    // cached roots
    always_ff @(posedge aclk) begin
        if (root_we) begin
            root_reg[ch_reg] <= root_wdata;
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // the output state reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (norm_go) begin
                        ch_reg    <= in_idx;
                        pix_reg   <= s_tdata;
                        state_reg <= root_valid_reg[in_idx] ? S_DIVSET : S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    prod_reg  <= cur_sum * cur_sum;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    state_reg <= diff_pos ? S_ROOT : S_DIVSET;
                end
                S_ROOT: begin
                    if (iter_done) begin
                        state_reg <= S_DIVSET;
                    end
                end
                S_DIVSET: begin
                    neg_reg <= num_neg;
                    if (cur_root == '0) begin
                        res_reg   <= '0;
                        zero_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (div_sat) begin
                        res_reg   <= num_neg ? OUT_MIN_C : OUT_MAX_C;
                        zero_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (iter_done) begin
                        res_reg   <= quo_signed;
                        zero_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= res_reg;
                        m_tuser_reg  <= zero_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(24-OUT_W){1'b0}}, m_tdata_reg};
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire
